>>> rtl/core/aip_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_pkg
// Shared types, character codes and digit decode for the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int BASE_BITS = 6;
    localparam int CHAR_BITS = 8;

    typedef logic [BASE_BITS-1:0] base_t;
    typedef logic [CHAR_BITS-1:0] char_t;

    // Character codes
    localparam char_t CH_ZERO   = 8'h30;  // '0'
    localparam char_t CH_NINE   = 8'h39;  // '9'
    localparam char_t CH_LO_A   = 8'h61;  // 'a'
    localparam char_t CH_LO_Z   = 8'h7A;  // 'z'
    localparam char_t CH_UP_A   = 8'h41;  // 'A'
    localparam char_t CH_UP_Z   = 8'h5A;  // 'Z'
    localparam char_t CH_LO_X   = 8'h78;  // 'x'
    localparam char_t CH_UP_X   = 8'h58;  // 'X'
    localparam char_t CH_LO_B   = 8'h62;  // 'b'
    localparam char_t CH_UP_B   = 8'h42;  // 'B'
    localparam char_t CH_PLUS   = 8'h2B;
    localparam char_t CH_MINUS  = 8'h2D;
    localparam char_t CH_SPACE  = 8'h20;
    localparam char_t CH_TAB    = 8'h09;
    localparam char_t CH_CR     = 8'h0D;
    localparam char_t CH_LO_OFS = 8'h57;  // 'a' - 10
    localparam char_t CH_UP_OFS = 8'h37;  // 'A' - 10

    // Radix values
    localparam base_t BASE_AUTO = 6'd0;
    localparam base_t BASE_2    = 6'd2;
    localparam base_t BASE_8    = 6'd8;
    localparam base_t BASE_10   = 6'd10;
    localparam base_t BASE_16   = 6'd16;
    localparam base_t BASE_36   = 6'd36;

    // Digit code for a character that is no digit in any radix
    localparam base_t DIGIT_NONE = 6'd63;

    // Register indexes
    localparam logic REG_NUMBER_BASE = 1'b0;
    localparam logic REG_SIGNED_MODE = 1'b1;

    // Radix update selects
    localparam logic [2:0] BOP_KEEP = 3'd0;  // hold the latched radix
    localparam logic [2:0] BOP_RAW  = 3'd1;  // latch configured radix as is
    localparam logic [2:0] BOP_DIG  = 3'd2;  // latch configured radix, auto -> 10
    localparam logic [2:0] BOP_HEX  = 3'd3;
    localparam logic [2:0] BOP_BIN  = 3'd4;
    localparam logic [2:0] BOP_OCT  = 3'd5;  // auto -> 8, else hold

    typedef struct packed {
        logic       step;       // beat accepted: advance the position
        logic       set_neg;
        logic [2:0] base_op;
        logic       take;       // try the beat's character as a digit
        logic       pend_zero;  // accept the held leading zero
        logic       fin_zero;   // accept a held zero at end of string
        logic       finish;     // load the result and clear the state
    } aip_cmd_t;

    typedef struct packed {
        logic  digit_ok;
        base_t active_base;
    } aip_stat_t;

    function automatic base_t digit_of(input char_t c);
        base_t d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            d = base_t'(c - CH_ZERO);
        end
        else if (c >= CH_LO_A && c <= CH_LO_Z)
        begin
            d = base_t'(c - CH_LO_OFS);
        end
        else if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            d = base_t'(c - CH_UP_OFS);
        end
        return d;
    endfunction

endpackage

>>> rtl/core/aip_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_ctrl
// Parse phase state machine and stream handshake control.
// ----------------------------------------------------------------------------
module aip_ctrl
    import aip_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  char_t     char_code,
    input  logic      last_char,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  base_t     number_base,
    input  aip_stat_t stat,
    output aip_cmd_t  cmd
);

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_SIGN   = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic       valid_reg;
    logic       valid_next;
    logic       accept;
    logic       is_space;
    logic       cfg_zero_ok;
    logic       hex_ok;
    logic       bin_ok;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = valid_reg;

    assign is_space    = (char_code >= CH_TAB && char_code <= CH_CR) || char_code == CH_SPACE;
    assign cfg_zero_ok = char_code == CH_ZERO &&
                         (number_base == BASE_AUTO || number_base == BASE_16 ||
                          number_base == BASE_2);
    assign hex_ok = (stat.active_base == BASE_AUTO || stat.active_base == BASE_16) &&
                    (char_code == CH_LO_X || char_code == CH_UP_X);
    assign bin_ok = (stat.active_base == BASE_AUTO || stat.active_base == BASE_2) &&
                    (char_code == CH_LO_B || char_code == CH_UP_B);

    always_comb
    begin
        cmd            = '0;
        cmd.base_op    = BOP_KEEP;
        phase_next     = phase_reg;
        valid_next     = valid_reg && !m_tready;
        if (accept)
        begin
            cmd.step = 1'b1;
            unique case (phase_reg)
                PH_SPACE, PH_SIGN:
                begin
                    if (phase_reg == PH_SPACE && is_space)
                    begin
                        phase_next = PH_SPACE;
                    end
                    else if (phase_reg == PH_SPACE && char_code == CH_MINUS)
                    begin
                        cmd.set_neg = 1'b1;
                        phase_next  = PH_SIGN;
                    end
                    else if (phase_reg == PH_SPACE && char_code == CH_PLUS)
                    begin
                        phase_next = PH_SIGN;
                    end
                    else if (cfg_zero_ok)
                    begin
                        // hold the zero until the prefix letter shows up
                        cmd.base_op = BOP_RAW;
                        phase_next  = PH_ZERO;
                    end
                    else
                    begin
                        cmd.base_op = BOP_DIG;
                        cmd.take    = 1'b1;
                        phase_next  = stat.digit_ok ? PH_DIGITS : PH_DONE;
                    end
                end
                PH_ZERO:
                begin
                    if (hex_ok)
                    begin
                        cmd.base_op = BOP_HEX;
                        phase_next  = PH_DIGITS;
                    end
                    else if (bin_ok)
                    begin
                        cmd.base_op = BOP_BIN;
                        phase_next  = PH_DIGITS;
                    end
                    else
                    begin
                        cmd.base_op   = BOP_OCT;
                        cmd.pend_zero = 1'b1;
                        cmd.take      = 1'b1;
                        phase_next    = stat.digit_ok ? PH_DIGITS : PH_DONE;
                    end
                end
                PH_DIGITS:
                begin
                    cmd.take   = 1'b1;
                    phase_next = stat.digit_ok ? PH_DIGITS : PH_DONE;
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
            if (last_char)
            begin
                cmd.fin_zero = phase_next == PH_ZERO;
                cmd.finish   = 1'b1;
                phase_next   = PH_SPACE;
                valid_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

endmodule

>>> rtl/core/aip_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_datapath
// Radix latch, digit decode, multiply-accumulate with saturation, positions
// and the result register.
// ----------------------------------------------------------------------------
module aip_datapath
    import aip_pkg::*;
#(
    parameter int WORD_BITS   = 32,
    parameter int OFFSET_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  aip_cmd_t               cmd,
    output aip_stat_t              stat,
    input  char_t                  char_code,
    input  base_t                  number_base,
    input  logic                   signed_mode,
    output logic [WORD_BITS-1:0]   parsed_value,
    output logic [OFFSET_BITS-1:0] end_offset,
    output logic                   converted,
    output logic                   range_error
);

    localparam int PROD_BITS = WORD_BITS + BASE_BITS;

    logic                   neg_reg,  neg_next;
    base_t                  base_reg, base_next;
    logic [WORD_BITS-1:0]   acc_reg,  acc_next;
    logic                   seen_reg, seen_next;
    logic                   ovf_reg,  ovf_next;
    logic [OFFSET_BITS-1:0] pos_reg,  pos_next;
    logic [OFFSET_BITS-1:0] stop_reg, stop_next;
    logic [WORD_BITS-1:0]   value_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic                   conv_reg;
    logic                   rerr_reg;

    base_t                  digit;
    logic                   digit_ok;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic [WORD_BITS-1:0]   limit;
    logic [PROD_BITS-1:0]   prod;
    logic [WORD_BITS-1:0]   value;

    assign digit    = digit_of(char_code);
    assign pos_inc  = (&pos_reg) ? pos_reg : pos_reg + 1'b1;

    always_comb
    begin
        case (cmd.base_op)
            BOP_RAW: base_next = number_base;
            BOP_DIG: base_next = (number_base == BASE_AUTO) ? BASE_10 : number_base;
            BOP_HEX: base_next = BASE_16;
            BOP_BIN: base_next = BASE_2;
            BOP_OCT: base_next = (base_reg == BASE_AUTO) ? BASE_8 : base_reg;
            default: base_next = base_reg;
        endcase
    end

    assign digit_ok         = base_next >= BASE_2 && base_next <= BASE_36 && digit < base_next;
    assign stat.digit_ok    = digit_ok;
    assign stat.active_base = base_reg;

    // Saturation bound: signed max, its magnitude plus one when negative, or all ones
    always_comb
    begin
        if (signed_mode)
        begin
            limit = neg_reg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
        end
        else
        begin
            limit = '1;
        end
    end

    assign prod = PROD_BITS'(acc_reg) * PROD_BITS'(base_next) + PROD_BITS'(digit);

    always_comb
    begin
        neg_next  = neg_reg || cmd.set_neg;
        acc_next  = acc_reg;
        seen_next = seen_reg;
        ovf_next  = ovf_reg;
        stop_next = stop_reg;
        pos_next  = cmd.step ? pos_inc : pos_reg;
        if (cmd.pend_zero)
        begin
            seen_next = 1'b1;
            stop_next = pos_reg;
        end
        if (cmd.take && digit_ok)
        begin
            // acc*b + d above the bound is the same test as acc > q or acc == q, d > r
            if (ovf_reg || prod > PROD_BITS'(limit))
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                acc_next = prod[WORD_BITS-1:0];
            end
            seen_next = 1'b1;
            stop_next = pos_inc;
        end
        if (cmd.fin_zero)
        begin
            seen_next = 1'b1;
            stop_next = pos_inc;
        end
    end

    assign value = ovf_next ? limit : (neg_reg ? WORD_BITS'(0) - acc_next : acc_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            neg_reg  <= 1'b0;
            base_reg <= BASE_AUTO;
            acc_reg  <= '0;
            seen_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            pos_reg  <= '0;
            stop_reg <= '0;
        end
        else if (cmd.finish)
        begin
            neg_reg  <= 1'b0;
            base_reg <= BASE_AUTO;
            acc_reg  <= '0;
            seen_reg <= 1'b0;
            ovf_reg  <= 1'b0;
            pos_reg  <= '0;
            stop_reg <= '0;
        end
        else
        begin
            neg_reg  <= neg_next;
            base_reg <= base_next;
            acc_reg  <= acc_next;
            seen_reg <= seen_next;
            ovf_reg  <= ovf_next;
            pos_reg  <= pos_next;
            stop_reg <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            value_reg  <= value;
            offset_reg <= seen_next ? stop_next : '0;
            conv_reg   <= seen_next;
            rerr_reg   <= ovf_next;
        end
    end

    assign parsed_value = value_reg;
    assign end_offset   = offset_reg;
    assign converted    = conv_reg;
    assign range_error  = rerr_reg;

endmodule

>>> rtl/core/ascii_integer_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_integer_parser_core
// Stream string-to-integer converter: one character per beat, one result
// beat per string.
// ----------------------------------------------------------------------------
//  Port group   Dir   Beat contents
//  s_*          in    tdata: char_code[7:0]; tlast: last_char
//  m_*          out   tdata: parsed_value, end_offset, converted, range_error
//  cfg_*        in    index 0: number_base[5:0], index 1: signed_mode[0]
//
//  One character per cycle while s_tready is high; the digit multiply-accumulate
//  and the bound compare sit in a single stage, so each beat settles in the
//  cycle it lands. The result beat leaves from an output register in the cycle
//  after the beat with tlast. While a result waits on m_tready, s_tready drops.
//  Reset restores radix 10 and signed mode and clears the parse state.
// ----------------------------------------------------------------------------
module ascii_integer_parser_core
    import aip_pkg::*;
#(
    parameter int WORD_BITS   = 32,
    parameter int OFFSET_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // char_code[7:0]
    input  logic               s_tlast,   // last_char
    output logic               m_tvalid,
    input  logic               m_tready,
    // parsed_value, end_offset, converted, range_error, zero pad (lowest bit up)
    output logic [((WORD_BITS+OFFSET_BITS+2+7)/8)*8-1:0] m_tdata,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [5:0]         cfg_wdata
);

    localparam int OUT_BITS  = WORD_BITS + OFFSET_BITS + 2;
    localparam int DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    base_t                  number_base_reg;
    logic                   signed_mode_reg;
    aip_cmd_t               cmd;
    aip_stat_t              stat;
    logic [WORD_BITS-1:0]   parsed_value;
    logic [OFFSET_BITS-1:0] end_offset;
    logic                   converted;
    logic                   range_error;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            number_base_reg <= BASE_10;
            signed_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_NUMBER_BASE: number_base_reg <= cfg_wdata;
                REG_SIGNED_MODE: signed_mode_reg <= cfg_wdata[0];
                default:         number_base_reg <= number_base_reg;
            endcase
        end
    end

    aip_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .char_code   (s_tdata),
        .last_char   (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .number_base (number_base_reg),
        .stat        (stat),
        .cmd         (cmd)
    );

    aip_datapath #(
        .WORD_BITS   (WORD_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .char_code    (s_tdata),
        .number_base  (number_base_reg),
        .signed_mode  (signed_mode_reg),
        .parsed_value (parsed_value),
        .end_offset   (end_offset),
        .converted    (converted),
        .range_error  (range_error)
    );

    assign m_tdata = DATA_BITS'({range_error, converted, end_offset, parsed_value});

endmodule
